@@ src/abmix_pkg.sv @@
// ----------------------------------------------------------------------------
// abmix_pkg
// Shared types and constants for the ARGB8888-over-RGB565 blend pipeline.
// ----------------------------------------------------------------------------
package abmix_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_OPACITY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MASK_ENABLE      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OPAQUE_THRESHOLD = 2'd2;

  // Configuration reset values
  localparam logic [7:0] OPACITY_RST   = 8'd255;
  localparam logic       MASK_EN_RST   = 1'b0;
  localparam logic [7:0] THRESHOLD_RST = 8'd253;

  // Full-weight and zero-weight mix values
  localparam logic [7:0] MIX_FULL = 8'hFF;
  localparam logic [7:0] MIX_NONE = 8'h00;

  // How the mix weight is formed from the first-stage product
  typedef enum logic [1:0] {
    MIX_SEL_ALPHA  = 2'd0,  // source alpha as is
    MIX_SEL_PROD8  = 2'd1,  // two-factor product, >> 8
    MIX_SEL_PROD16 = 2'd2   // three-factor product, >> 16
  } mix_sel_e;

  // Source truncated to 5/6/5 plus the destination pixel
  typedef struct packed {
    logic [4:0]  src_r;
    logic [5:0]  src_g;
    logic [4:0]  src_b;
    logic [15:0] dst;
  } pix_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
  } stage_ld_t;

endpackage

@@ src/abmix_mix.sv @@
// ----------------------------------------------------------------------------
// abmix_mix
// Mix weight stages: stage 1 forms alpha times mask or opacity, stage 2
// applies the opacity in the three-factor case and selects the weight.
// ----------------------------------------------------------------------------
module abmix_mix import abmix_pkg::*; (
  input  logic      clk_i,
  input  stage_ld_t ld_i,
  input  logic      mask_en_i,
  input  logic      opaque_i,
  input  logic [7:0] opacity_i,
  input  logic [7:0] alpha_i,
  input  logic [7:0] mask_i,
  input  pix_t      pix_i,
  output logic [7:0] mix_o,
  output pix_t      pix_o
);

  logic [15:0] prod1_d, prod1_q;
  logic [7:0]  alpha_q;
  logic [7:0]  opacity_q;
  mix_sel_e    sel_d, sel_q;
  pix_t        pix1_q;
  logic [7:0]  factor;

  logic [23:0] prod2;
  logic [7:0]  mix_d, mix_q;
  pix_t        pix2_q;

  // Stage 1: pick the second factor and the weight form
  always_comb begin
    factor  = mask_en_i ? mask_i : opacity_i;
    prod1_d = 16'(alpha_i) * 16'(factor);
    if (!mask_en_i) begin
      sel_d = opaque_i ? MIX_SEL_ALPHA : MIX_SEL_PROD8;
    end else begin
      sel_d = opaque_i ? MIX_SEL_PROD8 : MIX_SEL_PROD16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_s1) begin
      prod1_q   <= prod1_d;
      alpha_q   <= alpha_i;
      opacity_q <= opacity_i;
      sel_q     <= sel_d;
      pix1_q    <= pix_i;
    end
  end

  // Stage 2: fold in opacity for the three-factor case and select
  always_comb begin
    prod2 = 24'(prod1_q) * 24'(opacity_q);
    case (sel_q)
      MIX_SEL_ALPHA:  mix_d = alpha_q;
      MIX_SEL_PROD8:  mix_d = prod1_q[15:8];
      MIX_SEL_PROD16: mix_d = prod2[23:16];
      default:        mix_d = alpha_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_s2) begin
      mix_q  <= mix_d;
      pix2_q <= pix1_q;
    end
  end

  assign mix_o = mix_q;
  assign pix_o = pix2_q;

endmodule

@@ src/abmix_chan.sv @@
// ----------------------------------------------------------------------------
// abmix_chan
// Channel mix stage: weights each 5/6/5 channel by mix and 255-mix and
// packs the RGB565 result, with the keep-destination and full-source cases.
// ----------------------------------------------------------------------------
module abmix_chan import abmix_pkg::*; (
  input  logic       clk_i,
  input  stage_ld_t  ld_i,
  input  logic [7:0] mix_i,
  input  pix_t       pix_i,
  output logic [15:0] result_o
);

  logic [7:0]  inv;
  logic [12:0] sum_r;
  logic [13:0] sum_g;
  logic [12:0] sum_b;
  logic [15:0] result_d, result_q;

  // Weighted channel sums; the top bits of each land straight in 565
  always_comb begin
    inv   = MIX_FULL - mix_i;
    sum_r = 13'(pix_i.src_r) * 13'(mix_i) + 13'(pix_i.dst[15:11]) * 13'(inv);
    sum_g = 14'(pix_i.src_g) * 14'(mix_i) + 14'(pix_i.dst[10:5]) * 14'(inv);
    sum_b = 13'(pix_i.src_b) * 13'(mix_i) + 13'(pix_i.dst[4:0]) * 13'(inv);
    if (mix_i == MIX_NONE) begin
      result_d = pix_i.dst;
    end else if (mix_i == MIX_FULL) begin
      result_d = {pix_i.src_r, pix_i.src_g, pix_i.src_b};
    end else begin
      result_d = {sum_r[12:8], sum_g[13:8], sum_b[12:8]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_s3) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

@@ src/argb8888_over_rgb565_blend.sv @@
// Throughput: one word per cycle while the output is not stalled; three
// register stages (two mix-weight multiplies, then the channel multiplies)
// each with its own valid bit. A stalled output holds only the stages
// behind it that are full.
// Reset clears the stage valid bits and loads the configuration defaults
// (opacity 255, mask off, opaque threshold 253).
// ----------------------------------------------------------------------------
// argb8888_over_rgb565_blend
// Blends an ARGB8888 source pixel, with optional mask coverage and layer
// opacity, over an RGB565 destination pixel.
// ----------------------------------------------------------------------------
module argb8888_over_rgb565_blend import abmix_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  // input word
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         src_blue_i,
  input  logic [7:0]         src_green_i,
  input  logic [7:0]         src_red_i,
  input  logic [7:0]         src_alpha_i,
  input  logic [7:0]         mask_value_i,
  input  logic [15:0]        dest_pixel_i,
  // output word
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        result_pixel_o
);

  logic [7:0] opacity_q;
  logic       mask_en_q;
  logic [7:0] threshold_q;
  logic       opaque;

  logic       v1_q, v2_q, v3_q;
  logic       v1_d, v2_d, v3_d;
  logic       rdy1, rdy2, rdy3;
  stage_ld_t  ld;

  pix_t       pix_in;
  pix_t       pix_mix;
  logic [7:0] mix;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q   <= OPACITY_RST;
      mask_en_q   <= MASK_EN_RST;
      threshold_q <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GLOBAL_OPACITY:   opacity_q   <= cfg_wdata_i;
        CFG_MASK_ENABLE:      mask_en_q   <= cfg_wdata_i[0];
        CFG_OPAQUE_THRESHOLD: threshold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign opaque = (opacity_q >= threshold_q);

  // Ready chain: a stage takes a word when empty or when its successor moves
  always_comb begin
    rdy3 = !v3_q || !out_stall_i;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    ld.ld_s1 = rdy1 && in_valid_i;
    ld.ld_s2 = rdy2 && v1_q;
    ld.ld_s3 = rdy3 && v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v3_q;

  // Truncate the source to 565 up front
  assign pix_in = '{src_r: src_red_i[7:3], src_g: src_green_i[7:2],
                    src_b: src_blue_i[7:3], dst: dest_pixel_i};

  abmix_mix u_mix (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .mask_en_i (mask_en_q),
    .opaque_i  (opaque),
    .opacity_i (opacity_q),
    .alpha_i   (src_alpha_i),
    .mask_i    (mask_value_i),
    .pix_i     (pix_in),
    .mix_o     (mix),
    .pix_o     (pix_mix)
  );

  abmix_chan u_chan (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .mix_i    (mix),
    .pix_i    (pix_mix),
    .result_o (result_pixel_o)
  );

  // An empty first stage never pushes back on the input
  a_empty_s1_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // A zero weight passes the destination through
  a_mix_none_keeps_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld.ld_s3 && mix == MIX_NONE) |=> result_pixel_o == $past(pix_mix.dst))
    else $error("zero mix did not keep the destination");

  // A full weight gives the truncated source
  a_mix_full_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld.ld_s3 && mix == MIX_FULL) |=>
      result_pixel_o == $past({pix_mix.src_r, pix_mix.src_g, pix_mix.src_b}))
    else $error("full mix did not give the source");

  // A word leaving stage 2 always lands in the output stage
  a_s3_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld.ld_s3 |=> out_valid_o)
    else $error("output stage lost a word");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARGB8888-over-RGB565 blend. A queue-fed driver
// sends pixel words with random gaps, a monitor applies random output stalls
// and compares every result word against a bit-exact blend predictor. Runs a
// directed set covering each mix mode, then random words over several
// register settings.
// ----------------------------------------------------------------------------
module tb_top import abmix_pkg::*; ();

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int unsigned QuietLimit = 500;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseWords = 129;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [7:0]  mask;
    logic [15:0] dst;
  } src_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [7:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         src_blue_i = '0;
  logic [7:0]         src_green_i = '0;
  logic [7:0]         src_red_i = '0;
  logic [7:0]         src_alpha_i = '0;
  logic [7:0]         mask_value_i = '0;
  logic [15:0]        dest_pixel_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        result_pixel_o;

  // shadow copy of the configuration registers
  logic [7:0] opacity_q = OPACITY_RST;
  logic       mask_en_q = MASK_EN_RST;
  logic [7:0] threshold_q = THRESHOLD_RST;

  src_word_t   pixel_q[$];
  logic [15:0] blend_exp_q[$];

  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned received_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 30;
  int unsigned snk_idle_pct = 30;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;

  argb8888_over_rgb565_blend i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .src_blue_i    (src_blue_i),
    .src_green_i   (src_green_i),
    .src_red_i     (src_red_i),
    .src_alpha_i   (src_alpha_i),
    .mask_value_i  (mask_value_i),
    .dest_pixel_i  (dest_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_pixel_o(result_pixel_o)
  );

  always #2 clk_i = ~clk_i;

  // Blend one pixel with the current register settings
  function automatic logic [15:0] blend_pixel(src_word_t w);
    logic        opaque;
    int unsigned a, m, o;
    logic [7:0]  mix;
    logic [7:0]  inv;
    int unsigned sum_r, sum_g, sum_b;
    opaque = opacity_q >= threshold_q;
    a = w.alpha;
    m = w.mask;
    o = opacity_q;
    if (!mask_en_q && opaque) mix = w.alpha;
    else if (!mask_en_q) mix = 8'((a * o) >> 8);
    else if (opaque) mix = 8'((a * m) >> 8);
    else mix = 8'((a * m * o) >> 16);
    if (mix == MIX_NONE) return w.dst;
    if (mix == MIX_FULL) return {w.red[7:3], w.green[7:2], w.blue[7:3]};
    inv = MIX_FULL - mix;
    sum_r = w.red[7:3] * mix + w.dst[15:11] * inv;
    sum_g = w.green[7:2] * mix + w.dst[10:5] * inv;
    sum_b = w.blue[7:3] * mix + w.dst[4:0] * inv;
    return 16'(((sum_r << 3) & 32'hF800) + ((sum_g >> 3) & 32'h07E0) + (sum_b >> 8));
  endfunction

  function automatic int unsigned draw_gap(int unsigned pct);
    return ($urandom_range(99) < pct) ? $urandom_range(14, 1) : 0;
  endfunction

  // Alpha or mask value, leaning toward the ends of the range
  function automatic logic [7:0] pick_weight();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(2));
      3: return 8'($urandom_range(255, 253));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_pixel(input logic [7:0] b, g, r, a, m, input logic [15:0] d);
    pixel_q.push_back('{b, g, r, a, m, d});
    queued_cnt++;
  endtask

  // Wait until every queued word has been sent and its result checked
  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_cnt != queued_cnt || received_cnt != queued_cnt);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GLOBAL_OPACITY:   opacity_q = data;
      CFG_MASK_ENABLE:      mask_en_q = data[0];
      CFG_OPAQUE_THRESHOLD: threshold_q = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Driver: predict on accept, then hold, idle or present the next word
  always @(posedge clk_i or negedge rst_ni) begin : src_driver
    src_word_t cur;
    src_word_t nxt;
    logic      load;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      src_blue_i   <= '0;
      src_green_i  <= '0;
      src_red_i    <= '0;
      src_alpha_i  <= '0;
      mask_value_i <= '0;
      dest_pixel_i <= '0;
      src_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur = '{src_blue_i, src_green_i, src_red_i, src_alpha_i, mask_value_i, dest_pixel_i};
        blend_exp_q.push_back(blend_pixel(cur));
        accepted_cnt++;
        src_gap = draw_gap(src_idle_pct);
      end
      if (!(in_valid_i && in_stall_o)) begin
        load = 1'b0;
        if (src_gap != 0) begin
          src_gap--;
        end else if (pixel_q.size() != 0) begin
          nxt  = pixel_q.pop_front();
          load = 1'b1;
        end
        in_valid_i <= load;
        if (load) begin
          src_blue_i   <= nxt.blue;
          src_green_i  <= nxt.green;
          src_red_i    <= nxt.red;
          src_alpha_i  <= nxt.alpha;
          mask_value_i <= nxt.mask;
          dest_pixel_i <= nxt.dst;
        end
      end
    end
  end

  // Monitor: check each result word, then stall for a random stretch
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    logic [15:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (blend_exp_q.size() == 0) begin
          $error("result_pixel: no word expected, actual 0x%04h", result_pixel_o);
          error_cnt++;
        end else begin
          want = blend_exp_q.pop_front();
          received_cnt++;
          if (result_pixel_o !== want) begin
            $error("result_pixel: expected 0x%04h, actual 0x%04h", want, result_pixel_o);
            error_cnt++;
          end
        end
        snk_gap = draw_gap(snk_idle_pct);
      end else if (snk_gap != 0) begin
        snk_gap--;
      end
      out_stall_i <= (snk_gap != 0);
    end
  end

  // Abort when the pipeline stops moving
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned opa;
    int unsigned thr;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: mask off, opaque, so the mix is the source alpha
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 16'h1234);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'h0000);
    queue_pixel(8'h07, 8'h03, 8'h07, 8'hFF, 8'h5A, 16'hFFFF);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 16'h0000);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 16'hFFFF);
    queue_pixel(8'hAA, 8'h55, 8'hAA, 8'hFE, 8'h00, 16'hA5A5);
    queue_pixel(8'h55, 8'hAA, 8'h55, 8'h7F, 8'hFF, 16'h5A5A);
    wait_idle();

    // Opacity below threshold: alpha times opacity
    write_reg(CFG_GLOBAL_OPACITY, 8'h80);
    queue_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 16'h8421);
    wait_idle();

    // Opacity equal to threshold counts as opaque
    write_reg(CFG_OPAQUE_THRESHOLD, 8'h80);
    queue_pixel(8'h12, 8'h34, 8'h56, 8'hFF, 8'h00, 16'hFFFF);
    wait_idle();

    // Mask on, opaque: alpha times mask; upper data bits do not matter
    write_reg(CFG_MASK_ENABLE, 8'hFF);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'h5555);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    wait_idle();

    // Mask on, not opaque: three-factor product
    write_reg(CFG_OPAQUE_THRESHOLD, 8'hFF);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'hC0, 8'h80, 16'hFFFF);
    wait_idle();

    // Zero threshold: even zero opacity is opaque
    write_reg(CFG_GLOBAL_OPACITY, 8'h00);
    write_reg(CFG_OPAQUE_THRESHOLD, 8'h00);
    write_reg(CFG_MASK_ENABLE, 8'h00);
    queue_pixel(8'hF0, 8'hF0, 8'hF0, 8'hFF, 8'h00, 16'h0000);
    queue_pixel(8'h0F, 8'hF0, 8'h0F, 8'h80, 8'h00, 16'hF81F);
    wait_idle();

    // Write to the unused index must leave every register alone
    write_reg(CFG_SPARE_IDX, 8'hFF);
    queue_pixel(8'hC3, 8'h3C, 8'hC3, 8'hA0, 8'h00, 16'h07E0);
    wait_idle();

    // Random words over a series of settings, opacity and threshold extremes first
    for (int ph = 0; ph < RandPhases; ph++) begin
      opa = (ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(255);
      if (ph == 2) thr = 0;
      else if (ph == 3) thr = 255;
      else if (ph == 4) thr = opa;
      else if (ph == 5) thr = (opa == 255) ? 255 : opa + 1;
      else thr = $urandom_range(255);
      src_idle_pct = (ph % 3) * 40;
      snk_idle_pct = ((ph / 2) % 3) * 40;
      write_reg(CFG_GLOBAL_OPACITY, 8'(opa));
      write_reg(CFG_OPAQUE_THRESHOLD, 8'(thr));
      write_reg(CFG_MASK_ENABLE, (8'($urandom) & 8'hFE) | 8'(ph % 2));
      write_reg(CFG_SPARE_IDX, 8'($urandom));
      for (int n = 0; n < PhaseWords; n++)
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_weight(), pick_weight(),
                    16'($urandom));
      wait_idle();
    end

    // Let any stray words show up before closing
    repeat (DrainCycles) @(posedge clk_i);
    if (blend_exp_q.size() != 0) begin
      $error("result_pixel: %0d expected words never arrived", blend_exp_q.size());
      error_cnt++;
    end
    $display("tb: %0d pixels blended and compared over %0d register writes", received_cnt,
             cfg_writes);
    $display("tb: all four mix modes, zero/full mix and threshold edges, %0d mismatches",
             error_cnt);
    if (error_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
src/abmix_pkg.sv
src/abmix_mix.sv
src/abmix_chan.sv
src/argb8888_over_rgb565_blend.sv
verif/tb_top.sv
